>>> hdl/composite_sync_line_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Composite sync line tracker assertion macros
// Shared concurrent-assertion shorthands for the line tracker.
// ----------------------------------------------------------------------------
`ifndef COMPOSITE_SYNC_LINE_TRACKER_UNIT_DEFINES_SVH
`define COMPOSITE_SYNC_LINE_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/cslt_pkg.sv
// ----------------------------------------------------------------------------
// cslt_pkg
// Types, codes and defaults shared by the composite sync line tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package cslt_pkg;

	// Default sizing
	localparam int DEF_TIME_BITS     = 32;
	localparam int DEF_LINES_PER_ROW = 10;

	// Field widths
	localparam int TS_W       = 32;
	localparam int LINE_W     = 12;
	localparam int FIRST_W    = 10;
	localparam int ROWS_W     = 4;
	localparam int TICKS_W    = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Event opcodes
	localparam logic [1:0] OP_CSYNC = 2'd0;
	localparam logic [1:0] OP_VSYNC = 2'd1;
	localparam logic [1:0] OP_LOST  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYNC_POLARITY   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LINE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ROWS       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_SYNC_TICKS = 2'd3;

	// Line state codes
	localparam logic signed [LINE_W-1:0] LINE_EOF = -12'sd1;
	localparam logic signed [LINE_W-1:0] LINE_VBL = 12'sd0;
	localparam logic signed [LINE_W-1:0] LINE_SOF = 12'sd1;

	// Configuration register values after reset
	localparam logic               RST_SYNC_POLARITY   = 1'b0;
	localparam logic [FIRST_W-1:0] RST_FIRST_LINE      = 10'd30;
	localparam logic [ROWS_W-1:0]  RST_TEXT_ROWS       = 4'd2;
	localparam logic [TICKS_W-1:0] RST_LONG_SYNC_TICKS = 16'd720;

	typedef struct packed {
		logic [1:0]      opcode;
		logic            sync_level;
		logic [TS_W-1:0] timestamp;
		logic            display_on;
	} evt_t;

	typedef struct packed {
		logic signed [LINE_W-1:0] line_number;
		logic                     trigger_on;
		logic                     frame_start;
		logic                     display_start;
		logic                     frame_end;
	} res_t;

	typedef struct packed {
		logic               sync_polarity;
		logic [FIRST_W-1:0] first_line;
		logic [ROWS_W-1:0]  text_rows;
		logic [TICKS_W-1:0] long_sync_ticks;
	} cfg_t;

endpackage

`default_nettype wire

>>> hdl/cslt_cfg.sv
// ----------------------------------------------------------------------------
// cslt_cfg
// Configuration register file of the line tracker, one write per request.
// ----------------------------------------------------------------------------
`default_nettype none

module cslt_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              wr_en,
	input  wire logic [cslt_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [cslt_pkg::CFG_DATA_W-1:0]   wr_data,
	output cslt_pkg::cfg_t                         cfg
);
	import cslt_pkg::*;

	cfg_t cfg_q;

	// Decode the index and store the low bits of the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_polarity   <= RST_SYNC_POLARITY;
			cfg_q.first_line      <= RST_FIRST_LINE;
			cfg_q.text_rows       <= RST_TEXT_ROWS;
			cfg_q.long_sync_ticks <= RST_LONG_SYNC_TICKS;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_SYNC_POLARITY:   cfg_q.sync_polarity   <= wr_data[0];
				CFG_FIRST_LINE:      cfg_q.first_line      <= wr_data[FIRST_W-1:0];
				CFG_TEXT_ROWS:       cfg_q.text_rows       <= wr_data[ROWS_W-1:0];
				CFG_LONG_SYNC_TICKS: cfg_q.long_sync_ticks <= wr_data[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

>>> hdl/cslt_core.sv
// ----------------------------------------------------------------------------
// cslt_core
// Line state registers and the single-pass update for one sync event.
// ----------------------------------------------------------------------------
`default_nettype none

module cslt_core #(
	parameter int TIME_BITS     = cslt_pkg::DEF_TIME_BITS,
	parameter int LINES_PER_ROW = cslt_pkg::DEF_LINES_PER_ROW
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire cslt_pkg::evt_t evt,
	input  wire cslt_pkg::cfg_t cfg,
	output cslt_pkg::res_t   res
);
	import cslt_pkg::*;

	logic signed [LINE_W-1:0] line_q, line_d, line_inc;
	logic [TIME_BITS-1:0]     start_q, start_d, now, width;
	logic                     trig_q, trig_d;
	logic                     is_start, is_long;
	logic                     fstart, dstart, fend;
	logic [LINE_W-1:0]        bound, first_ext;

	// Pulse width in the tick domain; a negative width is never long
	assign now      = TIME_BITS'(evt.timestamp);
	assign width    = now - start_q;
	assign is_long  = !width[TIME_BITS-1] && (width > TIME_BITS'(cfg.long_sync_ticks));
	assign is_start = (evt.sync_level == cfg.sync_polarity);

	// Display window bounds
	assign first_ext = LINE_W'(cfg.first_line);
	assign bound     = first_ext + LINE_W'(cfg.text_rows) * LINE_W'(LINES_PER_ROW)
		+ LINE_W'(2);
	assign line_inc  = line_q + LINE_W'(1);

	// Next line state for the event
	always_comb begin
		line_d = line_q;
		trig_d = trig_q;
		start_d = start_q;
		fstart = 1'b0;
		dstart = 1'b0;
		fend = 1'b0;
		unique case (evt.opcode)
			OP_VSYNC: begin
				trig_d = 1'b0;
				line_d = LINE_VBL;
			end
			OP_LOST: begin
				trig_d = 1'b0;
				line_d = LINE_EOF;
			end
			OP_CSYNC: begin
				if (line_q <= LINE_VBL) begin
					// Measure pulses while idle or in vblank
					if (is_start) begin
						start_d = now;
					end else if (is_long) begin
						line_d = LINE_VBL;
					end else if (line_q == LINE_VBL) begin
						if (!evt.display_on) begin
							trig_d = 1'b0;
							line_d = LINE_EOF;
							fend = 1'b1;
						end else begin
							line_d = LINE_SOF;
							fstart = 1'b1;
						end
					end
				end else if (is_start) begin
					// Count lines inside the frame
					line_d = line_inc;
					if ($unsigned(line_inc) == first_ext) begin
						trig_d = 1'b1;
						dstart = 1'b1;
					end else if ($unsigned(line_inc) >= bound) begin
						trig_d = 1'b0;
						line_d = LINE_EOF;
						fend = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	// Advance the state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_EOF;
			trig_q <= 1'b0;
			start_q <= '0;
		end else if (accept) begin
			line_q <= line_d;
			trig_q <= trig_d;
			start_q <= start_d;
		end
	end

	assign res.line_number   = line_d;
	assign res.trigger_on    = trig_d;
	assign res.frame_start   = fstart;
	assign res.display_start = dstart;
	assign res.frame_end     = fend;

endmodule

`default_nettype wire

>>> hdl/composite_sync_line_tracker_unit.sv
// ----------------------------------------------------------------------------
// composite_sync_line_tracker_unit
// Follows the video line from timestamped composite-sync, vsync and
// lost-sync events and reports the line state after each event.
//
// Channels: evt (valid/stall) takes one event request, res (valid/stall)
// gives one result per event, cfg (valid/ready) writes a register; cfg is
// always ready.
// Result: registered, and shown in the cycle after its event is accepted.
// Throughput: one event per cycle unless stalled; the single result register
// lets the next event in while the current result is being taken.
// Stall: while a result waits under res_stall, evt_stall is raised and the
// line state holds.
// Reset: arst_n clears the line state to end of frame, the trigger, the
// pulse start time and the result valid, and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module composite_sync_line_tracker_unit #(
	parameter int TIME_BITS     = cslt_pkg::DEF_TIME_BITS,
	parameter int LINES_PER_ROW = cslt_pkg::DEF_LINES_PER_ROW
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              evt_valid,
	output      logic                              evt_stall,
	input  wire cslt_pkg::evt_t                    evt,
	output      logic                              res_valid,
	input  wire logic                              res_stall,
	output cslt_pkg::res_t                         res,
	input  wire logic                              cfg_valid,
	output      logic                              cfg_ready,
	input  wire logic [cslt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [cslt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import cslt_pkg::*;

`include "composite_sync_line_tracker_unit_defines.svh"

	cfg_t cfg;
	res_t res_d, res_s1;
	logic valid_q, evt_accept;

	assign cfg_ready = 1'b1;

	cslt_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Hold new requests only while a result is stuck at the output
	assign evt_stall  = valid_q && res_stall;
	assign evt_accept = evt_valid && !evt_stall;

	cslt_core #(
		.TIME_BITS     (TIME_BITS),
		.LINES_PER_ROW (LINES_PER_ROW)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (evt_accept),
		.evt    (evt),
		.cfg    (cfg),
		.res    (res_d)
	);

	// Result register: load on accept, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (evt_accept) begin
			valid_q <= 1'b1;
		end else if (!res_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_accept) begin
			res_s1 <= res_d;
		end
	end

	assign res_valid = valid_q;
	assign res       = res_s1;

	`CSLT_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, evt_accept, res_valid, "accepted event gave no result")
	`CSLT_ASSERT_NOW(a_one_pulse, clk, arst_n, res_valid, $onehot0({res.frame_start, res.display_start, res.frame_end}), "more than one pulse in a result")
	`CSLT_ASSERT_NOW(a_start_line, clk, arst_n, res_valid && res.frame_start, res.line_number == LINE_SOF, "frame start off the first line")
	`CSLT_ASSERT_NOW(a_end_state, clk, arst_n, res_valid && res.frame_end, res.line_number == LINE_EOF && !res.trigger_on, "frame end with live line state")

endmodule

`default_nettype wire
